// ===== src/sha1_pkg.sv =====
// sha1_pkg: request types, round constants and initial chaining values
// for the sha-1 hash engine; no dependencies

package sha1_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_present;
    logic       end_of_message;
  } sha1_in_t;

  typedef struct packed {
    logic [63:0] digest_upper;
    logic [63:0] digest_middle;
    logic [31:0] digest_lower;
  } sha1_out_t;

  localparam int unsigned NUM_ROUNDS = 80;
  localparam int unsigned BLK_WORDS  = 16;

  localparam logic [31:0] K_0 = 32'h5A827999;
  localparam logic [31:0] K_1 = 32'h6ED9EBA1;
  localparam logic [31:0] K_2 = 32'h8F1BBCDC;
  localparam logic [31:0] K_3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LEN_FIT_LAST = 6'd55;

endpackage

// ===== src/sha1_hash_engine_core.sv =====
// sha1_hash_engine_core: sha-1 over a byte stream, 16x32 block buffer memory,
// one round per cycle from a 16-tap schedule shift line; uses sha1_pkg
// a request without end_of_message is absorbed while idle; every 64th byte adds a
// compression (one buffer read, 80 rounds, one chaining add)
// a request with end_of_message adds one or two padding compressions, then
// the digest is registered once no earlier digest is held by out_stall
// synchronous active-low reset loads the initial chaining words and clears
// fill index and bit count; the block buffer memory is not cleared

module sha1_hash_engine_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  sha1_pkg::sha1_in_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output sha1_pkg::sha1_out_t out_data
);
  import sha1_pkg::*;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_ADD, ST_OUT} state_t;
  typedef enum logic [1:0] {BLK_FULL, BLK_MARK, BLK_ZERO} blk_mode_t;

  state_t      state_r;
  blk_mode_t   mode_r;
  logic        len_en_r;
  logic        fin_pend_r;
  logic [6:0]  cnt_r;
  logic [5:0]  fill_r;
  logic [63:0] bits_r;
  logic [31:0] h_r [5];
  logic [31:0] a_r, b_r, c_r, d_r, e_r;
  logic [31:0] w_r [BLK_WORDS];
  logic [31:0] rdata_r;
  logic        out_valid_r;
  sha1_out_t   out_data_r;

  logic [31:0] mem [BLK_WORDS];

  logic        accept;
  logic        wr_en;
  logic [5:0]  fill_new;
  logic        wrap;
  logic [6:0]  rnd;
  logic [31:0] blk_word;
  logic [31:0] w_cur;
  logic [31:0] w_mix;
  logic [31:0] f_val;
  logic [31:0] k_val;
  logic [31:0] t_val;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != ST_IDLE);
  assign wr_en    = accept && in_data.byte_present;
  assign fill_new = in_data.byte_present ? fill_r + 6'd1 : fill_r;
  assign wrap     = in_data.byte_present && (fill_r == 6'd63);
  assign rnd      = cnt_r - 7'd1;

  // block buffer, big-endian byte lanes
  always_ff @(posedge clk) begin
    if (wr_en) begin
      case (fill_r[1:0])
        2'd0:    mem[fill_r[5:2]][31:24] <= in_data.data_byte;
        2'd1:    mem[fill_r[5:2]][23:16] <= in_data.data_byte;
        2'd2:    mem[fill_r[5:2]][15:8]  <= in_data.data_byte;
        default: mem[fill_r[5:2]][7:0]   <= in_data.data_byte;
      endcase
    end
    rdata_r <= mem[cnt_r[3:0]];
  end

  // padding applied on the fly to the word read back
  always_comb begin
    logic [5:0] pos;
    logic [7:0] byte_v;
    blk_word = '0;
    for (int l = 0; l < 4; l++) begin
      pos    = {rnd[3:0], 2'(l)};
      byte_v = rdata_r[(3 - l) * 8 +: 8];
      if (mode_r != BLK_FULL) begin
        if (mode_r == BLK_ZERO || pos > fill_r) begin
          byte_v = '0;
        end else if (pos == fill_r) begin
          byte_v = PAD_MARK;
        end
      end
      blk_word[(3 - l) * 8 +: 8] = byte_v;
    end
    if (len_en_r && rnd[3:0] == 4'd14) begin
      blk_word = bits_r[63:32];
    end else if (len_en_r && rnd[3:0] == 4'd15) begin
      blk_word = bits_r[31:0];
    end
  end

  assign w_mix = w_r[13] ^ w_r[8] ^ w_r[2] ^ w_r[0];
  assign w_cur = (rnd < 7'(BLK_WORDS)) ? blk_word : {w_mix[30:0], w_mix[31]};

  always_comb begin
    if (rnd < 7'd20) begin
      f_val = (b_r & c_r) | (~b_r & d_r);
      k_val = K_0;
    end else if (rnd < 7'd40) begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_1;
    end else if (rnd < 7'd60) begin
      f_val = (b_r & c_r) | (b_r & d_r) | (c_r & d_r);
      k_val = K_2;
    end else begin
      f_val = b_r ^ c_r ^ d_r;
      k_val = K_3;
    end
  end

  assign t_val = {a_r[26:0], a_r[31:27]} + f_val + e_r + w_cur + k_val;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      mode_r      <= BLK_FULL;
      len_en_r    <= 1'b0;
      fin_pend_r  <= 1'b0;
      cnt_r       <= '0;
      fill_r      <= '0;
      bits_r      <= '0;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 5; i++) begin
        h_r[i] <= H_INIT[i];
      end
    end else begin
      if (out_valid_r && !out_stall && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            fill_r <= fill_new;
            if (in_data.byte_present) begin
              bits_r <= bits_r + 64'd8;
            end
            cnt_r <= '0;
            if (wrap) begin
              mode_r     <= BLK_FULL;
              len_en_r   <= 1'b0;
              fin_pend_r <= in_data.end_of_message;
              state_r    <= ST_RUN;
            end else if (in_data.end_of_message) begin
              mode_r   <= BLK_MARK;
              len_en_r <= (fill_new <= LEN_FIT_LAST);
              state_r  <= ST_RUN;
            end
          end
        end
        ST_RUN: begin
          if (cnt_r == '0) begin
            a_r <= h_r[0];
            b_r <= h_r[1];
            c_r <= h_r[2];
            d_r <= h_r[3];
            e_r <= h_r[4];
          end else begin
            a_r <= t_val;
            b_r <= a_r;
            c_r <= {b_r[1:0], b_r[31:2]};
            d_r <= c_r;
            e_r <= d_r;
            for (int i = 0; i < BLK_WORDS - 1; i++) begin
              w_r[i] <= w_r[i + 1];
            end
            w_r[BLK_WORDS - 1] <= w_cur;
          end
          if (cnt_r == 7'(NUM_ROUNDS)) begin
            state_r <= ST_ADD;
          end
          cnt_r <= cnt_r + 7'd1;
        end
        ST_ADD: begin
          h_r[0] <= h_r[0] + a_r;
          h_r[1] <= h_r[1] + b_r;
          h_r[2] <= h_r[2] + c_r;
          h_r[3] <= h_r[3] + d_r;
          h_r[4] <= h_r[4] + e_r;
          cnt_r  <= '0;
          if (mode_r == BLK_FULL) begin
            if (fin_pend_r) begin
              fin_pend_r <= 1'b0;
              mode_r     <= BLK_MARK;
              len_en_r   <= (fill_r <= LEN_FIT_LAST);
              state_r    <= ST_RUN;
            end else begin
              state_r <= ST_IDLE;
            end
          end else if (mode_r == BLK_MARK && !len_en_r) begin
            mode_r   <= BLK_ZERO;
            len_en_r <= 1'b1;
            state_r  <= ST_RUN;
          end else begin
            state_r <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!out_valid_r || !out_stall) begin
            out_data_r.digest_upper  <= {h_r[0], h_r[1]};
            out_data_r.digest_middle <= {h_r[2], h_r[3]};
            out_data_r.digest_lower  <= h_r[4];
            out_valid_r <= 1'b1;
            for (int i = 0; i < 5; i++) begin
              h_r[i] <= H_INIT[i];
            end
            fill_r     <= '0;
            bits_r     <= '0;
            fin_pend_r <= 1'b0;
            state_r    <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== src/sha1_checker.sv =====
// sha1_checker: port-level checks for sha1_hash_engine_core, bound to it below;
// uses sha1_pkg for the request types

module sha1_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input sha1_pkg::sha1_in_t  in_data,
  input logic                out_valid,
  input logic                out_stall,
  input sha1_pkg::sha1_out_t out_data
);
  import sha1_pkg::*;

  // a stalled digest holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("digest changed while stalled");

  // an empty request leaves the engine free
  a_empty_free: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.byte_present && !in_data.end_of_message
    |=> !in_stall)
    else $error("engine busy after empty request");

  // closing a message starts compression
  a_end_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.end_of_message |=> in_stall)
    else $error("engine free right after end of message");

  // a new digest appears only as the engine returns to idle
  a_digest_idle: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> !in_stall)
    else $error("digest issued while engine busy");

endmodule

bind sha1_hash_engine_core sha1_checker u_sha1_checker (.*);

// ===== dv/tb.sv =====
// tb: self-checking bench for sha1_hash_engine_core, random and directed byte streams
// with a built-in sha-1 digest predictor and random gaps and stalls on both sides
// depends on sha1_pkg and sha1_hash_engine_core

module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sha1_pkg::*;

  localparam logic [31:0] SHA_K0 = 32'h5A827999;
  localparam logic [31:0] SHA_K1 = 32'h6ED9EBA1;
  localparam logic [31:0] SHA_K2 = 32'h8F1BBCDC;
  localparam logic [31:0] SHA_K3 = 32'hCA62C1D6;
  localparam logic [31:0] SHA_IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [7:0] SHA_PAD = 8'h80;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  sha1_in_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  sha1_out_t out_data;

  sha1_in_t  request_q [$];
  sha1_out_t digest_q [$];
  int        mismatch_count = 0;
  int        send_pct = 0;
  int        recv_pct = 0;

  logic [31:0] hash_words [5];
  logic [7:0]  block_buf [64];
  logic [5:0]  fill_idx;
  logic [63:0] msg_bits;

  sha1_hash_engine_core dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic void start_message();
    for (int i = 0; i < 5; i++) hash_words[i] = SHA_IV[i];
    fill_idx = '0;
    msg_bits = '0;
  endfunction

  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, t, x;
    for (int i = 0; i < 16; i++)
      w[i] = {block_buf[4*i], block_buf[4*i+1], block_buf[4*i+2], block_buf[4*i+3]};
    for (int i = 16; i < 80; i++) begin
      x = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
      w[i] = {x[30:0], x[31]};
    end
    a = hash_words[0];
    b = hash_words[1];
    c = hash_words[2];
    d = hash_words[3];
    e = hash_words[4];
    for (int i = 0; i < 80; i++) begin
      if (i < 20) begin
        f = (b & c) | (~b & d);
        k = SHA_K0;
      end else if (i < 40) begin
        f = b ^ c ^ d;
        k = SHA_K1;
      end else if (i < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = SHA_K2;
      end else begin
        f = b ^ c ^ d;
        k = SHA_K3;
      end
      t = {a[26:0], a[31:27]} + f + e + w[i] + k;
      e = d;
      d = c;
      c = {b[1:0], b[31:2]};
      b = a;
      a = t;
    end
    hash_words[0] += a;
    hash_words[1] += b;
    hash_words[2] += c;
    hash_words[3] += d;
    hash_words[4] += e;
  endfunction

  // absorb one accepted request, queue the digest on end of message
  function automatic void absorb_request(sha1_in_t req);
    int pos;
    if (req.byte_present) begin
      block_buf[fill_idx] = req.data_byte;
      fill_idx = fill_idx + 6'd1;
      msg_bits = msg_bits + 64'd8;
      if (fill_idx == 6'd0) compress_block();
    end
    if (req.end_of_message) begin
      pos = int'(fill_idx);
      block_buf[pos] = SHA_PAD;
      pos++;
      if (pos > 56) begin
        while (pos < 64) begin
          block_buf[pos] = 8'h00;
          pos++;
        end
        compress_block();
        pos = 0;
      end
      while (pos < 56) begin
        block_buf[pos] = 8'h00;
        pos++;
      end
      for (int i = 0; i < 8; i++) block_buf[56+i] = msg_bits[63-8*i -: 8];
      compress_block();
      digest_q.push_back('{digest_upper:  {hash_words[0], hash_words[1]},
                           digest_middle: {hash_words[2], hash_words[3]},
                           digest_lower:  hash_words[4]});
      start_message();
    end
  endfunction

  task automatic add_request(logic [7:0] b, logic present, logic last);
    sha1_in_t req;
    req.data_byte      = b;
    req.byte_present   = present;
    req.end_of_message = last;
    request_q.push_back(req);
  endtask

  // random message with occasional empty requests mixed in
  task automatic add_message(int len, bit end_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(99) < 10) add_request(8'($urandom_range(255)), 1'b0, 1'b0);
      add_request(8'($urandom_range(255)), 1'b1, (i == len - 1) && end_on_byte);
    end
    if (!(end_on_byte && len > 0)) add_request(8'($urandom_range(255)), 1'b0, 1'b1);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (request_q.size() > 0 && $urandom_range(99) >= send_pct) begin
        in_data  <= request_q.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) absorb_request(in_data);
  end

  always @(posedge clk) begin : monitor
    sha1_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (digest_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) $display("unexpected digest %h", out_data);
      end else begin
        want = digest_q.pop_front();
        if (want.digest_upper !== out_data.digest_upper ||
            want.digest_middle !== out_data.digest_middle ||
            want.digest_lower !== out_data.digest_lower) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("digest mismatch: expected %h %h %h, got %h %h %h",
                     want.digest_upper, want.digest_middle, want.digest_lower,
                     out_data.digest_upper, out_data.digest_middle, out_data.digest_lower);
        end
      end
    end
  end

  initial begin
    #20_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    int items;
    int msgs;
    int len;
    int pick;
    start_message();
    for (int i = 0; i < 64; i++) block_buf[i] = 8'h00;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    for (int ph = 0; ph < 4; ph++) begin
      @(negedge clk);
      case (ph)
        0: begin send_pct = 0;  recv_pct = 0;  end
        1: begin send_pct = 77; recv_pct = 0;  end
        2: begin send_pct = 0;  recv_pct = 77; end
        default: begin send_pct = 28; recv_pct = 28; end
      endcase
      if (ph == 0) begin
        // empty requests, empty message, "abc", extreme bytes, end without a byte
        add_request(8'hFF, 1'b0, 1'b0);
        add_request(8'h00, 1'b0, 1'b1);
        add_request(8'h61, 1'b1, 1'b0);
        add_request(8'h62, 1'b1, 1'b0);
        add_request(8'h63, 1'b1, 1'b1);
        add_request(8'h00, 1'b1, 1'b0);
        add_request(8'hFF, 1'b1, 1'b0);
        add_request(8'hA5, 1'b0, 1'b0);
        add_request(8'h5A, 1'b0, 1'b1);
        add_request(8'hFF, 1'b1, 1'b1);
        add_request(8'hFF, 1'b0, 1'b1);
        add_request(8'h00, 1'b1, 1'b1);
      end
      items = 0;
      msgs = 0;
      while (items < 90 || msgs < 3) begin
        pick = $urandom_range(99);
        if (pick < 60)      len = $urandom_range(16);
        else if (pick < 90) len = $urandom_range(70, 50);
        else                len = $urandom_range(135, 110);
        add_message(len, 1'($urandom_range(1)));
        items += len + 1;
        msgs++;
      end
      do @(negedge clk); while (request_q.size() != 0 || in_valid || digest_q.size() != 0);
    end
    repeat (200) @(posedge clk);
    if (mismatch_count == 0 && digest_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== sha1_hash_engine_core.f =====
src/sha1_pkg.sv
src/sha1_hash_engine_core.sv
src/sha1_checker.sv
dv/tb.sv
